// File: rtl/lzwe_pkg.sv
package lzwe_pkg;

    localparam int CODE_WIDTH_DEF = 12;
    localparam int BYTE_W         = 8;
    localparam int OUT_CODE_W     = 12;
    localparam int FIRST_FREE     = 256;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PROBE,
        ST_MISS,
        ST_FLUSH,
        ST_CLR_RD,
        ST_CLR_WR
    } state_t;

endpackage

// File: rtl/lzwe_ram.sv
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/lzw_byte_encoder.sv
// LZW byte encoder. One byte per request on s_; codes leave on m_, at most two per
// request (the code of a failed match, then the flushed prefix when s_end_of_input
// is set, marked by m_stream_done). The dictionary is a hash table with linear
// probing in one RAM of 2^(CODE_WIDTH+1) entries, plus a code-to-slot RAM used to
// erase the stream's entries after the flush. Each probe is one hash RAM read. A
// stream's first byte only loads the prefix; a later byte probes until a match or an
// empty slot; a miss sends the prefix code and adds an entry. After the flush each
// entry added in the stream is erased: a code-to-slot RAM read, a hash RAM write.
// After reset the hash RAM is swept clean before the first byte is taken. Once all
// 2^CODE_WIDTH codes are given out no new entries are added until the stream ends.
module lzw_byte_encoder #(
    parameter int CODE_WIDTH = lzwe_pkg::CODE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lzwe_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_end_of_input,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lzwe_pkg::OUT_CODE_W-1:0] m_code,
    output logic                            m_stream_done
);

    import lzwe_pkg::*;

    localparam int CW     = CODE_WIDTH;
    localparam int SLOT_W = CW + 1;
    localparam int KEY_W  = CW + BYTE_W;
    localparam int ENT_W  = 1 + KEY_W + CW;
    localparam logic [CW:0] FREE0 = (CW+1)'(FIRST_FREE);

    function automatic logic [SLOT_W-1:0] hash_slot(input logic [CW-1:0] pfx,
                                                    input logic [BYTE_W-1:0] b);
        logic [SLOT_W-1:0] hb;
        hb = SLOT_W'(b) << (SLOT_W - BYTE_W);
        return {1'b0, pfx} ^ hb;
    endfunction

    function automatic logic [OUT_CODE_W-1:0] out_code(input logic [CW-1:0] pfx);
        logic [CW+OUT_CODE_W-1:0] ext;
        ext = {{OUT_CODE_W{1'b0}}, pfx};
        return ext[OUT_CODE_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CW-1:0]         prefix_reg, prefix_next;
    logic                  prefix_valid_reg, prefix_valid_next;
    logic [CW:0]           next_free_reg, next_free_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [CW:0]           ctr_reg, ctr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_CODE_W-1:0] m_code_reg, m_code_next;
    logic                  m_done_reg, m_done_next;

    logic              h_wr_en;
    logic [SLOT_W-1:0] h_wr_addr, h_rd_addr;
    logic [ENT_W-1:0]  h_wr_data, h_rd_data;
    logic              sr_wr_en;
    logic [CW-1:0]     sr_wr_addr, sr_rd_addr;
    logic [SLOT_W-1:0] sr_wr_data, sr_rd_data;

    logic            out_free;
    logic            ent_valid;
    logic [KEY_W-1:0] ent_key;
    logic [CW-1:0]   ent_code;
    logic            hit;
    logic            clr_last;

    lzwe_ram #(.WIDTH(ENT_W), .DEPTH(2**SLOT_W)) u_hash_ram (
        .aclk    (aclk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    lzwe_ram #(.WIDTH(SLOT_W), .DEPTH(2**CW)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (sr_wr_en),
        .wr_addr (sr_wr_addr),
        .wr_data (sr_wr_data),
        .rd_addr (sr_rd_addr),
        .rd_data (sr_rd_data)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign ent_valid = h_rd_data[ENT_W-1];
    assign ent_key   = h_rd_data[ENT_W-2 -: KEY_W];
    assign ent_code  = h_rd_data[CW-1:0];
    assign hit       = ent_valid && (ent_key == {prefix_reg, byte_reg});
    assign clr_last  = (ctr_reg + 1'b1) == next_free_reg;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_code        = m_code_reg;
    assign m_stream_done = m_done_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (&ctr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (prefix_valid_reg) state_next = ST_PROBE;
                    else if (s_end_of_input) state_next = ST_FLUSH;
                end
            end
            ST_PROBE: begin
                if (hit) state_next = last_reg ? ST_FLUSH : ST_IDLE;
                else if (!ent_valid) state_next = ST_MISS;
            end
            ST_MISS: begin
                if (out_free) state_next = last_reg ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (out_free) state_next = (next_free_reg != FREE0) ? ST_CLR_RD : ST_IDLE;
            end
            ST_CLR_RD: state_next = ST_CLR_WR;
            ST_CLR_WR: begin
                state_next = clr_last ? ST_IDLE : ST_CLR_RD;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        slot_next         = slot_reg;
        ctr_next          = ctr_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_code_next       = m_code_reg;
        m_done_next       = m_done_reg;
        h_wr_en           = 1'b0;
        h_wr_addr         = slot_reg;
        h_wr_data         = '0;
        h_rd_addr         = slot_reg;
        sr_wr_en          = 1'b0;
        sr_wr_addr        = next_free_reg[CW-1:0];
        sr_wr_data        = slot_reg;
        sr_rd_addr        = ctr_reg[CW-1:0];
        unique case (state_reg)
            ST_INIT: begin
                h_wr_en   = 1'b1;
                h_wr_addr = ctr_reg;
                ctr_next  = ctr_reg + 1'b1;
            end
            ST_IDLE: begin
                h_rd_addr = hash_slot(prefix_reg, s_data_byte);
                if (s_valid) begin
                    byte_next = s_data_byte;
                    last_next = s_end_of_input;
                    slot_next = hash_slot(prefix_reg, s_data_byte);
                    if (!prefix_valid_reg) begin
                        prefix_next       = CW'(s_data_byte);
                        prefix_valid_next = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                h_rd_addr = slot_reg + 1'b1;
                if (hit) begin
                    prefix_next = ent_code;
                end else if (ent_valid) begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = out_code(prefix_reg);
                    m_done_next  = 1'b0;
                    prefix_next  = CW'(byte_reg);
                    if (!next_free_reg[CW]) begin
                        h_wr_en        = 1'b1;
                        h_wr_data      = {1'b1, prefix_reg, byte_reg, next_free_reg[CW-1:0]};
                        sr_wr_en       = 1'b1;
                        next_free_next = next_free_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_code_next       = out_code(prefix_reg);
                    m_done_next       = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    ctr_next          = FREE0;
                end
            end
            ST_CLR_RD: begin
            end
            ST_CLR_WR: begin
                h_wr_en   = 1'b1;
                h_wr_addr = sr_rd_data;
                ctr_next  = ctr_reg + 1'b1;
                if (clr_last) next_free_next = FREE0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FREE0;
            ctr_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            ctr_reg          <= ctr_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        slot_reg   <= slot_next;
        m_code_reg <= m_code_next;
        m_done_reg <= m_done_next;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import lzwe_pkg::*;

    localparam int DICT_CODES   = 1 << CODE_WIDTH_DEF;
    localparam int KEY_W        = OUT_CODE_W + BYTE_W;
    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_ITEMS   = 250;
    localparam int TAIL_ITEMS   = 100;
    localparam int SETTLE       = 2 * DICT_CODES + 64;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic                  done;
    } lzw_code_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  s_end_of_input = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_CODE_W-1:0] m_code;
    logic                  m_stream_done;

    lzw_code_t             pending_codes[$];
    int unsigned           pair_code[logic [KEY_W-1:0]];
    logic [OUT_CODE_W-1:0] cur_prefix = '0;
    bit                    have_prefix = 1'b0;
    int unsigned           free_code = FIRST_FREE;

    bit                    quiet = 1'b1;
    bit                    hold_ready = 1'b0;
    int                    hold_count = 0;
    int                    bad_results = 0;
    int unsigned           cycles = 0;

    lzw_byte_encoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code         (m_code),
        .m_stream_done  (m_stream_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** lzw_byte_encoder: FAILED **");
            $finish;
        end
    end

    function automatic void add_code(input logic [OUT_CODE_W-1:0] c, input logic d);
        lzw_code_t entry;
        entry.code    = c;
        entry.done    = d;
        pending_codes = {pending_codes, entry};
    endfunction

    // expected codes for one accepted byte
    function automatic void lzw_encode(input logic [BYTE_W-1:0] data, input logic eoi);
        logic [KEY_W-1:0] key;
        if (!have_prefix) begin
            cur_prefix  = OUT_CODE_W'(data);
            have_prefix = 1'b1;
        end else begin
            key = {cur_prefix, data};
            if (pair_code.exists(key)) begin
                cur_prefix = OUT_CODE_W'(pair_code[key]);
            end else begin
                add_code(cur_prefix, 1'b0);
                if (free_code < DICT_CODES) begin
                    pair_code[key] = free_code;
                    free_code++;
                end
                cur_prefix = OUT_CODE_W'(data);
            end
        end
        if (eoi) begin
            add_code(cur_prefix, 1'b1);
            pair_code.delete();
            cur_prefix  = '0;
            have_prefix = 1'b0;
            free_code   = FIRST_FREE;
        end
    endfunction

    // receiver: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_ready && hold_count < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_count++;
        end else begin
            if (hold_ready) begin
                hold_ready = 1'b0;
                hold_count = 0;
            end
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        lzw_code_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected code %0d done %0b", m_code, m_stream_done);
            end else begin
                want = pending_codes.pop_front();
                if (m_code !== want.code || m_stream_done !== want.done) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("code mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.code, want.done, m_code, m_stream_done);
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eoi);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        lzw_encode(data, eoi);
    endtask

    task automatic drain(input int settle_cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge aclk);
        repeat (settle_cycles) @(posedge aclk);
    endtask

    task automatic test_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    // runs of one byte build chains; the 0xFF run's flush lands on a dictionary code
    task automatic test_repeat_runs();
        for (int i = 0; i < 7; i++)
            send_byte(8'h00, i == 6);
        for (int i = 0; i < 6; i++)
            send_byte(8'hFF, i == 5);
    endtask

    task automatic test_alternating();
        logic [BYTE_W-1:0] pattern [7] = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41};
        for (int i = 0; i < 7; i++)
            send_byte(pattern[i], i == 6);
    endtask

    // long stream fills the table with many entries, narrow tail reuses them
    task automatic test_long_stream();
        for (int i = 0; i < LONG_ITEMS; i++)
            send_byte(BYTE_W'($urandom_range(255)), 1'b0);
        for (int i = 0; i < TAIL_ITEMS; i++)
            send_byte(BYTE_W'($urandom_range(3)), i == TAIL_ITEMS - 1);
    endtask

    task automatic test_backpressure();
        hold_ready = 1'b1;
        for (int i = 0; i < 80; i++)
            send_byte(BYTE_W'($urandom_range(1)), (i % 20) == 19);
    endtask

    task automatic test_random_streams();
        int                sent;
        int                len;
        int                alpha;
        bit                narrow;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(40, 1);
            narrow = $urandom_range(9) < 7;
            alpha  = $urandom_range(8, 2);
            base   = BYTE_W'($urandom_range(255));
            for (int i = 0; i < len; i++) begin
                data = narrow ? BYTE_W'(base + $urandom_range(alpha - 1))
                              : BYTE_W'($urandom_range(255));
                send_byte(data, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        quiet = 1'b1;
        test_single_byte_streams();
        test_repeat_runs();
        test_alternating();
        test_long_stream();
        quiet = 1'b0;
        test_backpressure();
        test_random_streams();
        drain(SETTLE);

        if (bad_results == 0 && pending_codes.size() == 0)
            $display("** lzw_byte_encoder: PASSED **");
        else
            $display("** lzw_byte_encoder: FAILED **");
        $finish;
    end

endmodule
